// ===== src/cau_pkg.sv =====
package cau_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int PW        = 2 * WORD_BITS;
	localparam int XW        = PW + 2;
	localparam int DIV_STEPS = PW + FRAC_BITS;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);
	localparam int Q_DEPTH   = 4;
	localparam int QA_W      = $clog2(Q_DEPTH);
	localparam int QC_W      = $clog2(Q_DEPTH + 1);

	localparam logic signed [XW-1:0] SMAX = {{(XW-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
	localparam logic signed [XW-1:0] SMIN = {{(XW-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}};

	typedef logic signed [WORD_BITS-1:0] word_t;

	typedef enum logic [2:0] {
		CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_CONJ, CMD_NEG, CMD_SCALE, CMD_MAG
	} cmd_t;

	typedef struct packed {
		cmd_t  cmd;
		word_t ar;
		word_t ai;
		word_t br;
		word_t bi;
		logic  iter;
		logic  dz;
	} item_t;

	typedef struct packed {
		logic run;
		logic done;
	} itr_stat_t;

	typedef struct packed {
		logic                   neg_re;
		logic                   neg_im;
		logic [WORD_BITS+1:0]   mag_re;
		logic [WORD_BITS+1:0]   mag_im;
		logic [WORD_BITS-1:0]   root;
	} itr_res_t;

	typedef struct packed {
		word_t v;
		logic  ovf;
	} sat_t;

	function automatic sat_t saturate(input logic signed [XW-1:0] v);
		sat_t r;
		if (v > SMAX) begin
			r.v   = SMAX[WORD_BITS-1:0];
			r.ovf = 1'b1;
		end else if (v < SMIN) begin
			r.v   = SMIN[WORD_BITS-1:0];
			r.ovf = 1'b1;
		end else begin
			r.v   = v[WORD_BITS-1:0];
			r.ovf = 1'b0;
		end
		return r;
	endfunction

endpackage

// ===== src/cau_front.sv =====
module cau_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [2:0]                         cmd,
	input  logic signed [cau_pkg::WORD_BITS-1:0] a_real,
	input  logic signed [cau_pkg::WORD_BITS-1:0] a_imag,
	input  logic signed [cau_pkg::WORD_BITS-1:0] b_real,
	input  logic signed [cau_pkg::WORD_BITS-1:0] b_imag,
	output logic                               head_valid,
	output cau_pkg::item_t                     head,
	input  logic                               pop
);
	import cau_pkg::*;

	item_t           mem_q [Q_DEPTH];
	logic [QA_W-1:0] rd_q, wr_q;
	logic [QC_W-1:0] cnt_q;
	logic            push, zb;
	item_t           nxt;

	assign busy       = (cnt_q == QC_W'(Q_DEPTH));
	assign push       = start && !busy;
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];

	always_comb begin
		zb       = (b_real == '0) && (b_imag == '0);
		nxt.cmd  = cmd_t'(cmd);
		nxt.ar   = a_real;
		nxt.ai   = a_imag;
		nxt.br   = b_real;
		nxt.bi   = b_imag;
		nxt.iter = (nxt.cmd == CMD_MAG) || ((nxt.cmd == CMD_DIV) && !zb);
		nxt.dz   = (nxt.cmd == CMD_DIV) && zb;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/cau_iter.sv =====
module cau_iter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            launch,
	input  logic                            sqrt_mode,
	input  logic signed [cau_pkg::PW:0]     n_re,
	input  logic signed [cau_pkg::PW:0]     n_im,
	input  logic [cau_pkg::PW-1:0]          sqsum,
	input  logic                            ack,
	output cau_pkg::itr_stat_t              st,
	output cau_pkg::itr_res_t               res
);
	import cau_pkg::*;

	logic                 run_q, done_q, mode_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 neg_re_q, neg_im_q, bre_q, bim_q;
	logic [DIV_STEPS-1:0] nre_q, nim_q;
	logic [PW-1:0]        rre_q, rim_q, d_q, s_q;
	logic [WORD_BITS:0]   qre_q, qim_q, srem_q;
	logic [WORD_BITS-1:0] root_q;

	logic signed [PW:0]   abs_re, abs_im;
	logic [PW:0]          t_re, t_im, dx;
	logic                 ge_re, ge_im, ge_s;
	logic [WORD_BITS+2:0] ts, trial, ts_sub;
	logic [PW:0]          sub_re, sub_im;

	always_comb begin
		abs_re = n_re[PW] ? -n_re : n_re;
		abs_im = n_im[PW] ? -n_im : n_im;
		dx     = {1'b0, d_q};
		t_re   = {rre_q, nre_q[DIV_STEPS-1]};
		t_im   = {rim_q, nim_q[DIV_STEPS-1]};
		ge_re  = (t_re >= dx);
		ge_im  = (t_im >= dx);
		sub_re = t_re - dx;
		sub_im = t_im - dx;
		ts     = {srem_q, s_q[PW-1:PW-2]};
		trial  = {1'b0, root_q, 2'b01};
		ge_s   = (ts >= trial);
		ts_sub = ts - trial;
	end

	assign st.run     = run_q;
	assign st.done    = done_q;
	assign res.neg_re = neg_re_q;
	assign res.neg_im = neg_im_q;
	assign res.mag_re = {bre_q, qre_q};
	assign res.mag_im = {bim_q, qim_q};
	assign res.root   = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (launch) begin
				run_q <= 1'b1;
				cnt_q <= sqrt_mode ? CNT_W'(WORD_BITS) : CNT_W'(DIV_STEPS);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
			if (ack) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			mode_q   <= sqrt_mode;
			neg_re_q <= n_re[PW];
			neg_im_q <= n_im[PW];
			nre_q    <= {abs_re[PW-1:0], {FRAC_BITS{1'b0}}};
			nim_q    <= {abs_im[PW-1:0], {FRAC_BITS{1'b0}}};
			rre_q    <= '0;
			rim_q    <= '0;
			qre_q    <= '0;
			qim_q    <= '0;
			bre_q    <= 1'b0;
			bim_q    <= 1'b0;
			d_q      <= sqsum;
			s_q      <= sqsum;
			srem_q   <= '0;
			root_q   <= '0;
		end else if (run_q) begin
			if (mode_q) begin
				s_q    <= {s_q[PW-3:0], 2'b00};
				srem_q <= ge_s ? ts_sub[WORD_BITS:0] : ts[WORD_BITS:0];
				root_q <= {root_q[WORD_BITS-2:0], ge_s};
			end else begin
				nre_q <= {nre_q[DIV_STEPS-2:0], 1'b0};
				nim_q <= {nim_q[DIV_STEPS-2:0], 1'b0};
				rre_q <= ge_re ? sub_re[PW-1:0] : t_re[PW-1:0];
				rim_q <= ge_im ? sub_im[PW-1:0] : t_im[PW-1:0];
				qre_q <= {qre_q[WORD_BITS-1:0], ge_re};
				qim_q <= {qim_q[WORD_BITS-1:0], ge_im};
				bre_q <= bre_q | qre_q[WORD_BITS];
				bim_q <= bim_q | qim_q[WORD_BITS];
			end
		end
	end

endmodule

// ===== src/cau_back.sv =====
module cau_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 head_valid,
	input  cau_pkg::item_t                       head,
	output logic                                 pop,
	output logic                                 done,
	output logic signed [cau_pkg::WORD_BITS-1:0] res_real,
	output logic signed [cau_pkg::WORD_BITS-1:0] res_imag,
	output logic                                 div_zero,
	output logic                                 overflow
);
	import cau_pkg::*;

	logic                valid_s1, iter_s1, dz_s1;
	cmd_t                cmd_s1;
	word_t               ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [PW-1:0] prr_s1, pii_s1, pri_s1, pir_s1, sq0_s1, sq1_s1;

	logic                fire, launch;
	word_t               sx, sy;
	logic signed [PW:0]  n_re, n_im;
	logic [PW-1:0]       sqsum;
	itr_stat_t           st;
	itr_res_t            ir;
	logic signed [XW-1:0] re_w, im_w, mre, mim;
	logic                dz_w;
	sat_t                sre, sim;

	assign fire   = valid_s1 && (!iter_s1 || st.done);
	assign launch = valid_s1 && iter_s1 && !st.run && !st.done;
	assign pop    = head_valid && (!valid_s1 || fire);

	assign sx = (head.cmd == CMD_MAG) ? head.ar : head.br;
	assign sy = (head.cmd == CMD_MAG) ? head.ai : head.bi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pop) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1  <= head.cmd;
			iter_s1 <= head.iter;
			dz_s1   <= head.dz;
			ar_s1   <= head.ar;
			ai_s1   <= head.ai;
			br_s1   <= head.br;
			bi_s1   <= head.bi;
			prr_s1  <= PW'(head.ar) * PW'(head.br);
			pii_s1  <= PW'(head.ai) * PW'(head.bi);
			pri_s1  <= PW'(head.ar) * PW'(head.bi);
			pir_s1  <= PW'(head.ai) * PW'(head.br);
			sq0_s1  <= PW'(sx) * PW'(sx);
			sq1_s1  <= PW'(sy) * PW'(sy);
		end
	end

	assign n_re  = (PW+1)'(prr_s1) + (PW+1)'(pii_s1);
	assign n_im  = (PW+1)'(pir_s1) - (PW+1)'(pri_s1);
	assign sqsum = $unsigned(sq0_s1) + $unsigned(sq1_s1);

	cau_iter u_iter (
		.clk       (clk),
		.arst_n    (arst_n),
		.launch    (launch),
		.sqrt_mode (cmd_s1 == CMD_MAG),
		.n_re      (n_re),
		.n_im      (n_im),
		.sqsum     (sqsum),
		.ack       (fire),
		.st        (st),
		.res       (ir)
	);

	always_comb begin
		mre  = signed'(XW'(ir.mag_re));
		mim  = signed'(XW'(ir.mag_im));
		re_w = '0;
		im_w = '0;
		dz_w = 1'b0;
		case (cmd_s1)
			CMD_ADD: begin
				re_w = XW'(ar_s1) + XW'(br_s1);
				im_w = XW'(ai_s1) + XW'(bi_s1);
			end
			CMD_SUB: begin
				re_w = XW'(ar_s1) - XW'(br_s1);
				im_w = XW'(ai_s1) - XW'(bi_s1);
			end
			CMD_MUL: begin
				re_w = (XW'(prr_s1) - XW'(pii_s1)) >>> FRAC_BITS;
				im_w = (XW'(pri_s1) + XW'(pir_s1)) >>> FRAC_BITS;
			end
			CMD_DIV: begin
				if (dz_s1) begin
					re_w = SMAX;
					dz_w = 1'b1;
				end else begin
					re_w = ir.neg_re ? -mre : mre;
					im_w = ir.neg_im ? -mim : mim;
				end
			end
			CMD_CONJ: begin
				re_w = XW'(ar_s1);
				im_w = -XW'(ai_s1);
			end
			CMD_NEG: begin
				re_w = -XW'(ar_s1);
				im_w = -XW'(ai_s1);
			end
			CMD_SCALE: begin
				re_w = XW'(prr_s1) >>> FRAC_BITS;
				im_w = XW'(pir_s1) >>> FRAC_BITS;
			end
			CMD_MAG: begin
				re_w = signed'(XW'(ir.root));
			end
			default: begin
				re_w = '0;
			end
		endcase
		sre = saturate(re_w);
		sim = saturate(im_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_real <= sre.v;
			res_imag <= sim.v;
			div_zero <= dz_w;
			overflow <= sre.ovf | sim.ovf;
		end
	end

endmodule

// ===== src/complex_arithmetic_unit_top.sv =====
// Complex arithmetic unit on signed Q16.16 operands.
// Command channel: drive cmd, a_real, a_imag, b_real, b_imag and raise start;
// the transaction is taken at a rising edge with start high and busy low.
// busy rises only when the four-entry command queue is full.
// Result channel: done is high for exactly one cycle with res_real, res_imag,
// div_zero and overflow valid in that cycle; the receiver cannot stall it,
// so sample the result on that edge. Results leave in command order.
// Add, sub, mul, conj, neg, scale and divide by zero pass from the queue
// through the execute stage into the registered outputs; divide takes one
// quotient bit per cycle in the shared iterative unit and magnitude one
// root bit per cycle in the same unit.
// Throughput: one command per cycle for non-iterative commands; a divide or
// magnitude holds the execute stage until its iteration finishes while the
// queue keeps taking commands until it is full.
// Reset (arst_n low) empties the queue and drops any work in flight; done is
// low after reset.
module complex_arithmetic_unit_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [2:0]                           cmd,
	input  logic signed [cau_pkg::WORD_BITS-1:0] a_real,
	input  logic signed [cau_pkg::WORD_BITS-1:0] a_imag,
	input  logic signed [cau_pkg::WORD_BITS-1:0] b_real,
	input  logic signed [cau_pkg::WORD_BITS-1:0] b_imag,
	output logic                                 done,
	output logic signed [cau_pkg::WORD_BITS-1:0] res_real,
	output logic signed [cau_pkg::WORD_BITS-1:0] res_imag,
	output logic                                 div_zero,
	output logic                                 overflow
);
	import cau_pkg::*;

	logic  head_valid, pop;
	item_t head;

	cau_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.a_real     (a_real),
		.a_imag     (a_imag),
		.b_real     (b_real),
		.b_imag     (b_imag),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	cau_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.done       (done),
		.res_real   (res_real),
		.res_imag   (res_imag),
		.div_zero   (div_zero),
		.overflow   (overflow)
	);

endmodule

// ===== tb/cau_checker.sv =====
module cau_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  logic [2:0]      cmd,
	input  cau_pkg::word_t  a_real,
	input  cau_pkg::word_t  a_imag,
	input  cau_pkg::word_t  b_real,
	input  cau_pkg::word_t  b_imag,
	input  logic            done,
	input  cau_pkg::word_t  res_real,
	input  cau_pkg::word_t  res_imag,
	input  logic            div_zero,
	input  logic            overflow,
	output int              errors,
	output int              pending,
	output int              checked,
	output int              div_zero_seen,
	output int              overflow_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import cau_pkg::*;

	typedef logic signed [127:0] wide_t;

	typedef struct {
		word_t re;
		word_t im;
		logic  dz;
		logic  ovf;
	} cplx_result_t;

	cplx_result_t expected_results[$];

	function automatic word_t clamp_word(input wide_t v, inout logic ovf);
		wide_t hi, lo;
		hi = 128'sd2147483647;
		lo = -128'sd2147483648;
		if (v > hi) begin
			ovf = 1'b1;
			return word_t'(hi[31:0]);
		end
		if (v < lo) begin
			ovf = 1'b1;
			return word_t'(lo[31:0]);
		end
		return word_t'(v[31:0]);
	endfunction

	function automatic cplx_result_t complex_op(input cmd_t c, input word_t ar, input word_t ai,
			input word_t br, input word_t bi);
		wide_t ear, eai, ebr, ebi, re, im, d, n, q, cand, root;
		cplx_result_t r;
		logic ovf;
		ear = ar;
		eai = ai;
		ebr = br;
		ebi = bi;
		ovf = 1'b0;
		r.dz = 1'b0;
		im = '0;
		case (c)
			CMD_ADD: begin
				re = ear + ebr;
				im = eai + ebi;
			end
			CMD_SUB: begin
				re = ear - ebr;
				im = eai - ebi;
			end
			CMD_MUL: begin
				re = (ear * ebr - eai * ebi) >>> FRAC_BITS;
				im = (ear * ebi + eai * ebr) >>> FRAC_BITS;
			end
			CMD_DIV: begin
				d = ebr * ebr + ebi * ebi;
				if (d == 0) begin
					r.dz = 1'b1;
					re = 128'sd2147483647;
				end else begin
					re = ear * ebr + eai * ebi;
					n = (re < 0) ? -re : re;
					q = (n <<< FRAC_BITS) / d;
					re = (re < 0) ? -q : q;
					im = eai * ebr - ear * ebi;
					n = (im < 0) ? -im : im;
					q = (n <<< FRAC_BITS) / d;
					im = (im < 0) ? -q : q;
				end
			end
			CMD_CONJ: begin
				re = ear;
				im = -eai;
			end
			CMD_NEG: begin
				re = -ear;
				im = -eai;
			end
			CMD_SCALE: begin
				re = (ear * ebr) >>> FRAC_BITS;
				im = (eai * ebr) >>> FRAC_BITS;
			end
			default: begin
				d = ear * ear + eai * eai;
				root = '0;
				for (int b = 33; b >= 0; b--) begin
					cand = root | (wide_t'(1) <<< b);
					if (cand * cand <= d)
						root = cand;
				end
				re = root;
			end
		endcase
		r.re = clamp_word(re, ovf);
		r.im = clamp_word(im, ovf);
		r.ovf = ovf;
		return r;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		cplx_result_t exp_r;
		if (!arst_n) begin
			errors <= 0;
			checked <= 0;
			div_zero_seen <= 0;
			overflow_seen <= 0;
			expected_results.delete();
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					if (errors < 10)
						$display("%0t: result with nothing outstanding: re=%h im=%h",
							$time, res_real, res_imag);
					errors <= errors + 1;
				end else begin
					exp_r = expected_results.pop_front();
					checked <= checked + 1;
					if (exp_r.dz)
						div_zero_seen <= div_zero_seen + 1;
					if (exp_r.ovf)
						overflow_seen <= overflow_seen + 1;
					if (res_real !== exp_r.re || res_imag !== exp_r.im ||
							div_zero !== exp_r.dz || overflow !== exp_r.ovf) begin
						if (errors < 10) begin
							$display("%0t: mismatch exp re=%h im=%h dz=%b ovf=%b",
								$time, exp_r.re, exp_r.im, exp_r.dz, exp_r.ovf);
							$display("%0t:          got re=%h im=%h dz=%b ovf=%b",
								$time, res_real, res_imag, div_zero, overflow);
						end
						errors <= errors + 1;
					end
				end
			end
			if (start && !busy)
				expected_results.push_back(complex_op(cmd_t'(cmd), a_real, a_imag,
					b_real, b_imag));
		end
	end
endmodule

// ===== tb/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cau_pkg::*;

	localparam word_t WMAX = 32'sh7fffffff;
	localparam word_t WMIN = 32'sh80000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] cmd = '0;
	word_t a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
	logic done, div_zero, overflow;
	word_t res_real, res_imag;
	int errors, pending, checked, div_zero_seen, overflow_seen;
	int idle_pct;

	always #5 clk = ~clk;

	complex_arithmetic_unit_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.a_real(a_real), .a_imag(a_imag), .b_real(b_real), .b_imag(b_imag),
		.done(done), .res_real(res_real), .res_imag(res_imag),
		.div_zero(div_zero), .overflow(overflow)
	);

	cau_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.a_real(a_real), .a_imag(a_imag), .b_real(b_real), .b_imag(b_imag),
		.done(done), .res_real(res_real), .res_imag(res_imag),
		.div_zero(div_zero), .overflow(overflow), .errors(errors),
		.pending(pending), .checked(checked), .div_zero_seen(div_zero_seen),
		.overflow_seen(overflow_seen)
	);

	function automatic word_t pick_word();
		case ($urandom_range(9))
			0: return WMAX;
			1: return WMIN;
			2: return '0;
			3: return word_t'($urandom_range(2)) - 1;
			4, 5: return word_t'($signed($urandom_range(32'h3ffff)) - 32'sh1ffff);
			6: return word_t'($signed($urandom_range(32'h1ffffff)) - 32'sh1000000);
			default: return word_t'($urandom());
		endcase
	endfunction

	task automatic issue(input cmd_t c, input word_t ar, input word_t ai,
			input word_t br, input word_t bi);
		int gap;
		gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		a_real <= ar;
		a_imag <= ai;
		b_real <= br;
		b_imag <= bi;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		word_t br, bi;
		cmd_t c;
		idle_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int k = 0; k < 8; k++) begin
			issue(cmd_t'(k), WMAX, WMIN, WMAX, WMIN);
			issue(cmd_t'(k), WMIN, WMIN, WMIN, WMIN);
		end
		issue(CMD_DIV, 32'sh10000, 32'sh20000, '0, '0);
		issue(CMD_DIV, '0, '0, 32'sh10000, '0);
		issue(CMD_DIV, WMAX, WMAX, 32'sh1, '0);
		issue(CMD_NEG, WMIN, 32'sh1, '0, '0);
		issue(CMD_CONJ, 32'sh1, WMIN, '0, '0);
		issue(CMD_MUL, 32'sh10000, 32'sh10000, 32'sh10000, -32'sh10000);
		issue(CMD_MAG, 32'sh30000, 32'sh40000, '0, '0);
		issue(CMD_SCALE, -32'sh1, 32'sh1, 32'sh8000, '0);
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 54 : (ph == 3) ? 18 : 0;
			for (int i = 0; i < 490; i++) begin
				c = cmd_t'($urandom_range(7));
				br = pick_word();
				bi = pick_word();
				if (c == CMD_DIV && $urandom_range(9) == 0) begin
					br = '0;
					bi = '0;
				end
				issue(c, pick_word(), pick_word(), br, bi);
			end
			drain();
		end
		repeat (100) @(posedge clk);
		$display("Checked %0d transactions over all eight commands and four idle mixes;",
			checked);
		$display("%0d hit a zero divisor and %0d saturated.", div_zero_seen, overflow_seen);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// ===== filelist.f =====
src/cau_pkg.sv
src/cau_front.sv
src/cau_iter.sv
src/cau_back.sv
src/complex_arithmetic_unit_top.sv
tb/cau_checker.sv
tb/tb.sv
